// ===== hdl/b64sd_pkg.sv =====
package b64sd_pkg;

  // field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned AccW    = 12;
  localparam int unsigned SextetW = 6;
  localparam int unsigned PendW   = 3;

  // configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register word indexes
  typedef enum logic [0:0] {
    RegOutLimit = 1'b0
  } reg_idx_e;

  localparam logic [CountW-1:0] OutLimitReset = 16'hFFFF;

  // alphabet decode: valid flag and sextet value
  typedef struct packed {
    logic               ok;
    logic [SextetW-1:0] value;
  } sextet_t;

  function automatic sextet_t b64_decode(input logic [CharW-1:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = SextetW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = SextetW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = SextetW'(62);
    end else if (c == 8'h2F) begin
      r.value = SextetW'(63);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // space, tab, lf, vt, ff, cr
  function automatic logic is_white(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

// ===== hdl/b64sd_if.sv =====
interface b64sd_in_if;
  import b64sd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_in_block;

  modport source (output valid, output char_code, output last_in_block, input ready);
  modport sink   (input valid, input char_code, input last_in_block, output ready);
endinterface

interface b64sd_out_if;
  import b64sd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  data_byte;
  logic              byte_valid;
  logic              block_end;
  logic [CountW-1:0] byte_count;

  modport source (output valid, output data_byte, output byte_valid, output block_end,
                  output byte_count, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input block_end,
                  input byte_count, output ready);
endinterface

// ===== hdl/base64_stream_decoder.sv =====
// channel   dir  payload                                        handshake
// in_i      in   char_code[7:0], last_in_block                  valid/ready
// out_o     out  data_byte[7:0], byte_valid, block_end,         valid/ready
//                byte_count[15:0]
// apb       in   out_limit at byte address 0                    psel/penable, pready high
//
// one character per cycle sustained while out_o is not stalled; each character
// is registered in the input register and then decoded into the result
// register, from which its result is offered.
// reset clears the decode state and sets out_limit to 65535; no clearing pass.
// a stall on out_o holds the result register, then the input register, then
// drops in_i.ready; whitespace and dropped bytes yield a word only at a block end.
module base64_stream_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  b64sd_in_if.sink                       in_i,
  b64sd_out_if.source                    out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [b64sd_pkg::ApbAddrW-1:0] paddr,
  input  logic [b64sd_pkg::ApbDataW-1:0] pwdata,
  output logic [b64sd_pkg::ApbDataW-1:0] prdata,
  output logic                           pready
);
  import b64sd_pkg::*;

  // configuration register
  logic [CountW-1:0] out_limit_q;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (reg_idx_e'(paddr[2]) == RegOutLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= OutLimitReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      out_limit_q <= pwdata[CountW-1:0];
    end
  end

  assign prdata = reg_hit ? ApbDataW'(out_limit_q) : '0;

  // input register
  logic             in_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             advance;

  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q <= in_i.char_code;
      last_q <= in_i.last_in_block;
    end
  end

  // decode state
  logic [AccW-1:0]   acc_q,     acc_d;
  logic [PendW-1:0]  pend_q,    pend_d;
  logic              halted_q,  halted_d;
  logic [CountW-1:0] emitted_q, emitted_d;

  // decode step
  sextet_t          sx;
  logic             consume;
  logic [PendW:0]   bits;
  logic [AccW-1:0]  acc_new;
  logic             have_byte;
  logic [ByteW-1:0] byte_val;
  logic             has_result;

  always_comb begin
    sx        = b64_decode(char_q);
    consume   = !halted_q && !is_white(char_q);
    acc_new   = {acc_q[AccW-SextetW-1:0], sx.value};
    bits      = {1'b0, pend_q} + (PendW+1)'(SextetW);
    have_byte = 1'b0;
    byte_val  = '0;
    acc_d     = acc_q;
    pend_d    = pend_q;
    halted_d  = halted_q;
    emitted_d = emitted_q;
    if (consume) begin
      if (!sx.ok) begin
        halted_d = 1'b1;
      end else begin
        acc_d = acc_new;
        if (bits >= (PendW+1)'(ByteW)) begin
          bits = bits - (PendW+1)'(ByteW);
          if (emitted_q < out_limit_q) begin
            byte_val  = ByteW'(acc_new >> bits);
            emitted_d = emitted_q + CountW'(1);
            have_byte = 1'b1;
          end
        end
        pend_d = bits[PendW-1:0];
      end
    end
    has_result = have_byte || last_q;
  end

  // result register
  logic              out_valid_q;
  logic [ByteW-1:0]  data_q;
  logic              bvalid_q;
  logic              bend_q;
  logic [CountW-1:0] count_q;

  assign advance = in_valid_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      pend_q      <= '0;
      halted_q    <= 1'b0;
      emitted_q   <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= has_result;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        if (last_q) begin
          acc_q     <= '0;
          pend_q    <= '0;
          halted_q  <= 1'b0;
          emitted_q <= '0;
        end else begin
          acc_q     <= acc_d;
          pend_q    <= pend_d;
          halted_q  <= halted_d;
          emitted_q <= emitted_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      data_q   <= byte_val;
      bvalid_q <= have_byte;
      bend_q   <= last_q;
      count_q  <= emitted_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_byte  = data_q;
  assign out_o.byte_valid = bvalid_q;
  assign out_o.block_end  = bend_q;
  assign out_o.byte_count = count_q;

endmodule

// ===== tb/tb_base64_stream_decoder.sv =====
module tb_base64_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b64sd_pkg::*;

  // one decoded word as seen on the output channel
  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic              byte_valid;
    logic              block_end;
    logic [CountW-1:0] byte_count;
  } dec_word_t;

  localparam int unsigned NumItems    = 700;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles  = 90;

  // characters that stop decoding or get skipped
  localparam logic [CharW-1:0] ChPad   = 8'h3D;
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChVt    = 8'h0B;
  localparam logic [CharW-1:0] ChFf    = 8'h0C;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChTop   = 8'hFF;

  // decode state mirror and the queue of words still owed by the block
  class b64_decode_check;
    logic [CountW-1:0] limit;
    logic [AccW-1:0]   acc;
    logic [PendW-1:0]  pend;
    logic              halted;
    logic [CountW-1:0] emitted;
    dec_word_t         owed_words[$];
    int unsigned       mismatches;

    function new();
      limit      = OutLimitReset;
      mismatches = 0;
      clear_block();
    endfunction

    function void clear_block();
      acc     = '0;
      pend    = '0;
      halted  = 1'b0;
      emitted = '0;
    endfunction

    function bit is_space(logic [CharW-1:0] c);
      return (c == ChSpace) || (c >= ChTab && c <= ChCr);
    endfunction

    // alphabet position, or -1 outside the alphabet
    function int sextet_of(logic [CharW-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
      if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
      if (c == 8'h2B) return 62;
      if (c == 8'h2F) return 63;
      return -1;
    endfunction

    function bit count_mismatch();
      mismatches++;
      return mismatches <= MaxReports;
    endfunction

    // advance the decode state by one accepted character
    function void take_char(logic [CharW-1:0] c, logic last);
      int          v;
      int unsigned bits;
      dec_word_t   w;
      w = '0;
      if (!halted && !is_space(c)) begin
        v = sextet_of(c);
        if (v < 0) begin
          halted = 1'b1;
        end else begin
          bits = pend + 6;
          acc  = {acc[AccW-SextetW-1:0], SextetW'(v)};
          if (bits >= 8) begin
            bits -= 8;
            if (emitted < limit) begin
              w.data_byte  = ByteW'(acc >> bits);
              w.byte_valid = 1'b1;
              emitted++;
            end
          end
          pend = PendW'(bits);
        end
      end
      if (w.byte_valid || last) begin
        w.block_end  = last;
        w.byte_count = emitted;
        owed_words.push_back(w);
      end
      if (last) clear_block();
    endfunction

    function void report(string what, dec_word_t want, dec_word_t got);
      if (count_mismatch())
        $display("%s: expected byte %02h valid %0b end %0b count %0d, got byte %02h valid %0b end %0b count %0d",
                 what, want.data_byte, want.byte_valid, want.block_end, want.byte_count,
                 got.data_byte, got.byte_valid, got.block_end, got.byte_count);
    endfunction

    // compare a delivered word with the oldest owed one
    function void match_word(dec_word_t got);
      dec_word_t want;
      if (owed_words.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      want = owed_words.pop_front();
      if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
          got.block_end !== want.block_end || got.byte_count !== want.byte_count)
        report("word mismatch", want, got);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  b64sd_in_if  char_if ();
  b64sd_out_if word_if ();

  b64_decode_check decoder = new();

  bit          hold_req;
  bit          no_gaps;
  int unsigned chars_used;
  int unsigned cycle_count;

  base64_stream_decoder u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (char_if),
    .out_o   (word_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_base64_stream_decoder: done, errors");
    $finish;
  end

  // receiver: random stalls, and a long hold-off on request
  initial begin : receiver
    int unsigned left;
    int unsigned r;
    logic        level;
    left  = 0;
    level = 1'b0;
    word_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        level    = 1'b0;
        left     = HoldCycles;
      end else if (left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          level = 1'b1;
          left  = $urandom_range(1, 20);
        end else if (r < 65) begin
          level = 1'b1;
          left  = $urandom_range(40, 120);
        end else if (r < 92) begin
          level = 1'b0;
          left  = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          left  = $urandom_range(10, 40);
        end
      end else begin
        left--;
      end
      word_if.ready <= level;
    end
  end

  // output check; values at the falling edge are those seen at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && word_if.valid === 1'b1 && word_if.ready === 1'b1)
      decoder.match_word(dec_word_t'{word_if.data_byte, word_if.byte_valid,
                                     word_if.block_end, word_if.byte_count});
  end

  // sender gap before a character, usually none
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      char_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_char(logic [CharW-1:0] c, logic last);
    idle_gap();
    char_if.valid         <= 1'b1;
    char_if.char_code     <= c;
    char_if.last_in_block <= last;
    do @(negedge clk_i); while (char_if.ready !== 1'b1);
    @(posedge clk_i);
    decoder.take_char(c, last);
    chars_used++;
  endtask

  function automatic logic [CharW-1:0] alpha_char();
    int unsigned v;
    v = $urandom_range(0, 63);
    if (v < 26) return CharW'(8'h41 + v);
    if (v < 52) return CharW'(8'h61 + v - 26);
    if (v < 62) return CharW'(8'h30 + v - 52);
    return (v == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [CharW-1:0] space_char();
    int unsigned r;
    r = $urandom_range(0, 5);
    return (r == 5) ? ChSpace : CharW'(ChTab + r);
  endfunction

  // a character that halts decoding
  function automatic logic [CharW-1:0] bad_char();
    case ($urandom_range(0, 3))
      0: return ChPad;
      1: return ChNul;
      2: return CharW'(8'h80 + $urandom_range(0, 127));
      default: return CharW'(8'h21 + $urandom_range(0, 9));
    endcase
  endfunction

  // one block: mostly well-formed text, some broken, some raw noise
  task automatic send_block(int unsigned len, bit clean);
    logic [CharW-1:0] text[$];
    logic             mid_last[$];
    int unsigned      kind;
    int unsigned      i;
    kind = clean ? 0 : $urandom_range(0, 99);
    for (i = 0; i < len; i++) begin
      if (kind < 85 && $urandom_range(0, 9) == 0) begin
        text.push_back(space_char());
        mid_last.push_back(1'b0);
      end
      if (kind < 85) text.push_back(alpha_char());
      else text.push_back(CharW'($urandom_range(0, 255)));
      mid_last.push_back(kind >= 85 && $urandom_range(0, 7) == 0);
    end
    if (kind < 70) begin
      // optional padding and trailing space
      repeat ($urandom_range(0, 2)) begin
        text.push_back(ChPad);
        mid_last.push_back(1'b0);
      end
      if ($urandom_range(0, 4) == 0) begin
        text.push_back(space_char());
        mid_last.push_back(1'b0);
      end
    end else if (kind < 85) begin
      // halt part way, then more text that is ignored
      text.insert($urandom_range(0, text.size()), bad_char());
      mid_last.push_back(1'b0);
    end
    for (i = 0; i < text.size(); i++)
      send_char(text[i], (i == text.size() - 1) ? 1'b1 : mid_last[i]);
  endtask

  // wait until every owed word has come, then let the pipeline settle
  task automatic drain();
    char_if.valid <= 1'b0;
    do @(posedge clk_i); while (decoder.owed_words.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write, then read back the limit
  task automatic write_reg(int unsigned idx, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == int'(RegOutLimit)) decoder.limit = value[CountW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'(4 * int'(RegOutLimit));
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[CountW-1:0] !== decoder.limit && decoder.count_mismatch())
      $display("out_limit read back %0d, expected %0d", prdata[CountW-1:0], decoder.limit);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CountW-1:0] limits[NumPhases];
    int unsigned       p;
    rst_ni                <= 1'b0;
    char_if.valid         <= 1'b0;
    char_if.char_code     <= '0;
    char_if.last_in_block <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    hold_req   = 1'b0;
    no_gaps    = 1'b0;
    chars_used = 0;
    limits[0]  = '0;
    limits[1]  = CountW'(1);
    limits[2]  = CountW'($urandom_range(3, 20));
    limits[3]  = CountW'(2);
    limits[4]  = CountW'($urandom_range(0, 65535));
    limits[5]  = OutLimitReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unmapped word: limit must stay at its reset value
    write_reg(int'(RegOutLimit) + 1, ApbDataW'($urandom));

    // three bytes with a space inside, last character carries a byte
    send_char("T", 1'b0);   send_char("W", 1'b0);   send_char(ChSpace, 1'b0);
    send_char("F", 1'b0);   send_char("u", 1'b1);
    // top alphabet values, then padding halts the block
    send_char("/", 1'b0);   send_char("/", 1'b0);   send_char(ChPad, 1'b0);
    send_char(ChPad, 1'b1);
    // zero byte, nul halts, later text ignored
    send_char("A", 1'b0);   send_char("A", 1'b0);   send_char(ChNul, 1'b0);
    send_char("B", 1'b1);
    // lone high code as the whole block
    send_char(ChTop, 1'b1);
    // other ends of the ranges, every whitespace code but space, whitespace last
    send_char("z", 1'b0);   send_char("9", 1'b0);   send_char("+", 1'b0);
    send_char(ChLf, 1'b0);  send_char(ChVt, 1'b0);  send_char(ChFf, 1'b0);
    send_char(ChTab, 1'b0); send_char(ChCr, 1'b1);
    drain();

    // random blocks under several limits
    for (p = 0; p < NumPhases; p++) begin
      write_reg(int'(RegOutLimit), {CountW'($urandom), limits[p]});
      if (p == 2) begin
        // hold the output off while the input keeps coming
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        send_block(48, 1'b1);
        no_gaps  = 1'b0;
      end
      while (chars_used < (NumItems * (p + 1)) / NumPhases) begin
        if ($urandom_range(0, 9) == 0) send_block($urandom_range(13, 60), 1'b0);
        else send_block($urandom_range(1, 12), 1'b0);
      end
      drain();
    end

    if (decoder.mismatches == 0 && decoder.owed_words.size() == 0) begin
      $display("tb_base64_stream_decoder: done, clean");
    end else begin
      $display("tb_base64_stream_decoder: done, errors");
    end
    $finish;
  end

endmodule
